FILE: rtl/core/psird_pkg.sv
// ----------------------------------------------------------------------------
// psird_pkg - shared types for the psi residual distribution block
// Holds the node record passed from the loader to the solver.
// ----------------------------------------------------------------------------
package psird_pkg;

  localparam int unsigned ACC_W = 40;
  localparam int unsigned CFG_ZERO_THRESHOLD = 0;

  // node record carried through the queue
  typedef struct packed {
    logic [31:0] state;
    logic [31:0] k;
    logic [31:0] k_plus;
    logic [31:0] k_minus;
    logic        last;
  } node_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PREP,
    S_UT_DIV,
    S_DIFF,
    S_NUM,
    S_BETA_DIV,
    S_BETA_ACC,
    S_SCALE_DIV,
    S_RES_MUL,
    S_RES_OUT
  } solve_state_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > 64'sd2147483647) r = 64'sd2147483647;
    else if (x < -64'sd2147483648) r = -64'sd2147483648;
    else r = x;
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [63:0] x);
    logic signed [ACC_W-1:0] r;
    if (x > 64'sd549755813887) r = {1'b0, {(ACC_W-1){1'b1}}};
    else if (x < -64'sd549755813888) r = {1'b1, {(ACC_W-1){1'b0}}};
    else r = x[ACC_W-1:0];
    return r;
  endfunction

  function automatic logic near_zero(input logic signed [63:0] d, input logic [7:0] thr);
    logic [63:0] mag;
    mag = d[63] ? 64'(-d) : 64'(d);
    return mag <= {56'd0, thr};
  endfunction

endpackage

FILE: rtl/core/psird_div.sv
// ----------------------------------------------------------------------------
// psird_div - iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module psird_div (
  input  logic               clk,
  input  logic               rst_n,
  input  psird_pkg::div_req_t req,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[62:0], q_r[63]};
    trial    = {1'b0, shifted} - {1'b0, d_r};
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.num[63] ? 64'(-req.num) : 64'(req.num);
      d_nxt    = req.den[63] ? 64'(-req.den) : 64'(req.den);
      neg_nxt  = req.num[63] ^ req.den[63];
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

FILE: rtl/core/psird_front.sv
// ----------------------------------------------------------------------------
// psird_front - node input queue
// Small fifo of node records between the input stream and the solver.
// ----------------------------------------------------------------------------
module psird_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  psird_pkg::node_t     wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output psird_pkg::node_t     rd_data
);

  psird_pkg::node_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/psird_back.sv
// ----------------------------------------------------------------------------
// psird_back - cell solver
// Accumulates nodes, then runs the inflow, beta and scale divisions on a
// shared divider (skipped on fault or near-zero denominators) and streams out one residual per stored node.
// ----------------------------------------------------------------------------
module psird_back #(
  parameter int unsigned MAX_NODES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       thr,
  input  logic             nd_valid,
  output logic             nd_ready,
  input  psird_pkg::node_t nd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [31:0]      res_value,
  output logic             res_last,
  output logic             res_fault
);

  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = psird_pkg::ACC_W;

  logic signed [31:0] st_mem_r [MAX_NODES];
  logic signed [31:0] kp_mem_r [MAX_NODES];
  logic signed [31:0] beta_r   [MAX_NODES];

  psird_pkg::solve_state_t state_r, state_nxt;
  logic signed [AW-1:0] phi_r, phi_nxt, win_r, win_nxt, wsum_r, wsum_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          fault_r, fault_nxt;
  logic signed [31:0] ut_r, ut_nxt, diff_r, diff_nxt, scale_r, scale_nxt;
  logic signed [63:0] num_r, num_nxt, prod_r, prod_nxt;
  logic signed [AW-1:0] sbeta_r, sbeta_nxt;
  logic signed [31:0] beta_wr;
  logic          beta_we;
  logic          out_v_r, out_v_nxt;
  logic [31:0]   out_d_r, out_d_nxt;
  logic          out_l_r, out_l_nxt, out_f_r, out_f_nxt;

  psird_pkg::div_req_t dreq;
  logic              dbusy, ddone;
  logic signed [63:0] dquot;

  psird_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .busy (dbusy),
    .done (ddone),
    .quot (dquot)
  );

  logic signed [63:0] p_ku, p_kmu;
  logic               take;

  assign p_ku     = ($signed(nd_data.k) * $signed(nd_data.state)) >>> 16;
  assign p_kmu    = ($signed(nd_data.k_minus) * $signed(nd_data.state)) >>> 16;
  assign nd_ready = (state_r == psird_pkg::S_LOAD);
  assign take     = nd_valid && nd_ready;

  always_comb begin
    state_nxt = state_r;
    phi_nxt   = phi_r;
    win_nxt   = win_r;
    wsum_nxt  = wsum_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    fault_nxt = fault_r;
    ut_nxt    = ut_r;
    diff_nxt  = diff_r;
    scale_nxt = scale_r;
    num_nxt   = num_r;
    prod_nxt  = prod_r;
    sbeta_nxt = sbeta_r;
    beta_we   = 1'b0;
    beta_wr   = '0;
    out_v_nxt = out_v_r && !res_ready;
    out_d_nxt = out_d_r;
    out_l_nxt = out_l_r;
    out_f_nxt = out_f_r;
    dreq      = '0;
    case (state_r)
      psird_pkg::S_LOAD: begin
        if (take) begin
          if (cnt_r < CW'(MAX_NODES)) begin
            cnt_nxt  = cnt_r + CW'(1);
            phi_nxt  = psird_pkg::sat40(64'(phi_r) + p_ku);
            win_nxt  = psird_pkg::sat40(64'(win_r) + p_kmu);
            wsum_nxt = psird_pkg::sat40(64'(wsum_r) + 64'($signed(nd_data.k_minus)));
          end else begin
            ovf_nxt = 1'b1;
          end
          if (nd_data.last) state_nxt = psird_pkg::S_PREP;
        end
      end
      psird_pkg::S_PREP: begin
        fault_nxt = ovf_r || psird_pkg::near_zero(64'(wsum_r), thr);
        idx_nxt   = '0;
        sbeta_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = psird_pkg::S_LOAD;
          phi_nxt = '0; win_nxt = '0; wsum_nxt = '0; ovf_nxt = 1'b0;
        end else if (ovf_r || psird_pkg::near_zero(64'(wsum_r), thr)) begin
          scale_nxt = '0;
          state_nxt = psird_pkg::S_RES_MUL;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = 64'(win_r) <<< 16;
          dreq.den   = 64'(wsum_r);
          state_nxt  = psird_pkg::S_UT_DIV;
        end
      end
      psird_pkg::S_UT_DIV: begin
        if (ddone) begin
          ut_nxt    = 32'(psird_pkg::sat32(dquot));
          state_nxt = psird_pkg::S_DIFF;
        end
      end
      psird_pkg::S_DIFF: begin
        diff_nxt  = 32'(psird_pkg::sat32(64'(st_mem_r[idx_r]) - 64'(ut_r)));
        state_nxt = psird_pkg::S_NUM;
      end
      psird_pkg::S_NUM: begin
        num_nxt = ($signed(kp_mem_r[idx_r]) * diff_r) >>> 16;
        if (psird_pkg::near_zero(64'(phi_r), thr)) begin
          state_nxt = psird_pkg::S_BETA_ACC;
          prod_nxt  = '0;
        end else begin
          state_nxt = psird_pkg::S_BETA_DIV;
        end
      end
      psird_pkg::S_BETA_DIV: begin
        if (!dbusy && !ddone) begin
          dreq.start = 1'b1;
          dreq.num   = num_r <<< 16;
          dreq.den   = 64'(phi_r);
        end
        if (ddone) begin
          prod_nxt  = psird_pkg::sat32(dquot);
          state_nxt = psird_pkg::S_BETA_ACC;
        end
      end
      psird_pkg::S_BETA_ACC: begin
        beta_we   = 1'b1;
        beta_wr   = prod_r[63] ? 32'sd0 : 32'(prod_r);
        sbeta_nxt = sbeta_r + AW'($signed(beta_wr));
        if (32'(idx_r) == 32'(cnt_r) - 1) begin
          idx_nxt = '0;
          if (psird_pkg::near_zero(64'(sbeta_nxt), thr)) begin
            scale_nxt = '0;
            state_nxt = psird_pkg::S_RES_MUL;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = 64'(phi_r) <<< 16;
            dreq.den   = 64'(sbeta_nxt);
            state_nxt  = psird_pkg::S_SCALE_DIV;
          end
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = psird_pkg::S_DIFF;
        end
      end
      psird_pkg::S_SCALE_DIV: begin
        if (ddone) begin
          scale_nxt = 32'(psird_pkg::sat32(dquot));
          state_nxt = psird_pkg::S_RES_MUL;
        end
      end
      psird_pkg::S_RES_MUL: begin
        prod_nxt  = fault_r ? 64'sd0 : (64'(beta_r[idx_r]) * 64'(scale_r)) >>> 16;
        state_nxt = psird_pkg::S_RES_OUT;
      end
      psird_pkg::S_RES_OUT: begin
        if (!out_v_r || res_ready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = 32'(psird_pkg::sat32(prod_r));
          out_f_nxt = fault_r;
          out_l_nxt = 32'(idx_r) == 32'(cnt_r) - 1;
          if (out_l_nxt) begin
            state_nxt = psird_pkg::S_LOAD;
            cnt_nxt = '0; phi_nxt = '0; win_nxt = '0; wsum_nxt = '0; ovf_nxt = 1'b0;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = psird_pkg::S_RES_MUL;
          end
        end
      end
      default: state_nxt = psird_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && cnt_r < CW'(MAX_NODES)) begin
      st_mem_r[cnt_r[IW-1:0]] <= nd_data.state;
      kp_mem_r[cnt_r[IW-1:0]] <= nd_data.k_plus;
    end
    if (beta_we) beta_r[idx_r] <= beta_wr;
    // fault cells read beta as zero via fault flag
    ut_r    <= ut_nxt;
    diff_r  <= diff_nxt;
    scale_r <= scale_nxt;
    num_r   <= num_nxt;
    prod_r  <= prod_nxt;
    sbeta_r <= sbeta_nxt;
    idx_r   <= idx_nxt;
    fault_r <= fault_nxt;
    out_d_r <= out_d_nxt;
    out_l_r <= out_l_nxt;
    out_f_r <= out_f_nxt;
    if (!rst_n) begin
      state_r <= psird_pkg::S_LOAD;
      phi_r   <= '0;
      win_r   <= '0;
      wsum_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phi_r   <= phi_nxt;
      win_r   <= win_nxt;
      wsum_r  <= wsum_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign res_valid = out_v_r;
  assign res_value = out_d_r;
  assign res_last  = out_l_r;
  assign res_fault = out_f_r;

endmodule

FILE: rtl/core/psi_residual_distribution.sv
// ----------------------------------------------------------------------------
// psi_residual_distribution - scalar psi residual distribution
// Loads the nodes of a cell and emits one distributed residual per node.
// ----------------------------------------------------------------------------
// usage:
//   in_* stream carries one node per transfer; in_tlast closes the cell.
//   out_* stream returns one residual per stored node in load order after
//   the closing node; out_tlast marks the last residual, out_tuser the fault.
//   cfg_* writes zero_threshold at address 0.
// operation:
//   a non-closing node passes through the queue and one accumulate step.
//   a closing node starts the solve: one division for the inflow state,
//   one per node for beta and one for the scale, all on the single shared
//   radix-2 divider (a fault or a near-zero denominator skips them), plus
//   per-node steps for products, divider handshakes and output.
// reset clears the accumulators, node count and output valid; threshold 0.
// a stalled receiver holds the output register and the solver waits; the
// two-entry input queue keeps accepting nodes until full.
// ----------------------------------------------------------------------------
module psi_residual_distribution #(
  parameter int unsigned MAX_NODES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // node_state, node_k, node_k_plus, node_k_minus
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // node_residual
  output logic [31:0]  out_tdata,
  output logic         out_tlast,
  // cell_fault
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [7:0] thr_r;
  psird_pkg::node_t in_node, q_node;
  logic q_valid, q_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'(psird_pkg::CFG_ZERO_THRESHOLD)) ? {24'd0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == 1'(psird_pkg::CFG_ZERO_THRESHOLD)) begin
      thr_r <= cfg_pwdata[7:0];
    end
  end

  assign in_node.state   = in_tdata[31:0];
  assign in_node.k       = in_tdata[63:32];
  assign in_node.k_plus  = in_tdata[95:64];
  assign in_node.k_minus = in_tdata[127:96];
  assign in_node.last    = in_tlast;

  psird_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_tvalid),
    .wr_ready(in_tready),
    .wr_data (in_node),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_node)
  );

  psird_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr      (thr_r),
    .nd_valid (q_valid),
    .nd_ready (q_ready),
    .nd_data  (q_node),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_value(out_tdata),
    .res_last (out_tlast),
    .res_fault(out_tuser)
  );

endmodule

FILE: rtl/core/psird_checker.sv
// ----------------------------------------------------------------------------
// psird_checker - port-level checks
// Watches the top level's stream and config ports.
// ----------------------------------------------------------------------------
module psird_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("fault residual not zero");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

  a_ready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind psi_residual_distribution psird_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_pready(cfg_pready)
);
